@@ rtl/bcba_pkg.sv @@
// Package for the bitmap block allocator: opcodes, widths and shared types.
// No dependencies.
package bcba_pkg;

    localparam int BlocksDefault = 256;
    localparam int SizeW = 25;
    localparam int OffW = 24;
    localparam int ShiftW = 5;
    localparam int ShiftMax = 16;
    localparam int WordW = 8;
    localparam logic [ShiftW-1:0] ShiftReset = 5'd6;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    // Classified request handed from the front end to the executor.
    typedef struct packed {
        op_t         op;
        logic        reject;
        logic [12:0] start;
        logic [12:0] count;
        logic [12:0] limit;
        logic [4:0]  shift;
    } req_t;

endpackage

@@ rtl/bitmap_contiguous_block_allocator_core.sv @@
// Top level of the bitmap first-fit block allocator.
// Depends on bcba_pkg, bcba_front and bcba_exec.
//
// A command (allocate or free) transfers when start is high and busy is low. Each command
// yields exactly one result, shown for one cycle while done is high; the receiver cannot
// stall it. The executor walks the bitmap one block per cycle: an allocate scans for a free
// run and then marks it, and a free clears its blocks; a rejected command goes straight
// to its result. The front end holds one command while the executor works, so the next
// command can wait in it. block_shift is written through cfg_we/cfg_data; the user is to
// write it only while idle, which the block itself does not enforce; values above 16 act as 16.
module bitmap_contiguous_block_allocator_core
    import bcba_pkg::*;
#(
    parameter int BLOCKS = BlocksDefault
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [ShiftW-1:0] cfg_data,
    input  logic              start,
    output logic              busy,
    input  logic              opcode,
    input  logic [SizeW-1:0]  size_bytes,
    input  logic [OffW-1:0]   offset_bytes,
    output logic              done,
    output logic              ok,
    output logic [OffW-1:0]   alloc_offset
);

    logic [ShiftW-1:0] shift_reg;
    logic              q_valid;
    logic              q_pop;
    req_t              q_req;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg <= ShiftReset;
        end
        else if (cfg_we)
        begin
            shift_reg <= cfg_data;
        end
    end

    bcba_front #(.BLOCKS(BLOCKS)) u_front (
        .clk(clk), .rst_n(rst_n), .start(start), .opcode(opcode),
        .size_bytes(size_bytes), .offset_bytes(offset_bytes), .shift_cfg(shift_reg),
        .busy(busy), .q_valid(q_valid), .q_req(q_req), .q_pop(q_pop)
    );

    bcba_exec #(.BLOCKS(BLOCKS)) u_exec (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_req(q_req), .q_pop(q_pop),
        .done(done), .ok(ok), .alloc_offset(alloc_offset)
    );

endmodule

@@ rtl/bcba_front.sv @@
// Front end: accepts commands, rounds sizes to blocks and queues them.
// Depends on bcba_pkg.
module bcba_front
    import bcba_pkg::*;
#(
    parameter int BLOCKS = BlocksDefault
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              opcode,
    input  logic [SizeW-1:0]  size_bytes,
    input  logic [OffW-1:0]   offset_bytes,
    input  logic [ShiftW-1:0] shift_cfg,
    output logic              busy,
    output logic              q_valid,
    output req_t              q_req,
    input  logic              q_pop
);

    logic [4:0]  sh;
    logic [25:0] rounded;
    logic [24:0] nblk;
    logic [24:0] lim_span;
    logic [12:0] limit;
    logic [23:0] sblk;
    req_t        req;
    logic        full_reg;
    logic        full_next;
    req_t        req_reg;

    always_comb
    begin
        sh = (shift_cfg > 5'(ShiftMax)) ? 5'(ShiftMax) : shift_cfg;
        rounded = {1'b0, size_bytes} + ((26'd1 << sh) - 26'd1);
        nblk = 25'(rounded >> sh);
        lim_span = 25'((25'd1 << 24) >> sh);
        limit = (lim_span < 25'(BLOCKS)) ? 13'(lim_span) : 13'(BLOCKS);
        sblk = offset_bytes >> sh;
        req.op = op_t'(opcode);
        req.shift = sh;
        req.limit = limit;
        req.start = (sblk < 24'(limit)) ? 13'(sblk) : 13'd0;
        req.count = (nblk > 25'(limit)) ? limit : 13'(nblk);
        if (size_bytes == '0)
        begin
            req.reject = 1'b1;
        end
        else if (opcode == OP_ALLOC)
        begin
            req.reject = nblk > 25'(limit);
        end
        else
        begin
            req.reject = sblk >= 24'(limit);
        end
        full_next = full_reg;
        if (q_pop)
        begin
            full_next = 1'b0;
        end
        if (start && !busy)
        begin
            full_next = 1'b1;
        end
    end

    assign busy = full_reg;
    assign q_valid = full_reg;
    assign q_req = req_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else
        begin
            full_reg <= full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            req_reg <= req;
        end
    end

endmodule

@@ rtl/bcba_exec.sv @@
// Back end: first-fit search and run marking over the block bitmap.
// Depends on bcba_pkg.
module bcba_exec
    import bcba_pkg::*;
#(
    parameter int BLOCKS = BlocksDefault
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    input  req_t            q_req,
    output logic            q_pop,
    output logic            done,
    output logic            ok,
    output logic [OffW-1:0] alloc_offset
);

    localparam int IW = $clog2(BLOCKS);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SEARCH = 5'b00010,
        S_MARK   = 5'b00100,
        S_CLEAR  = 5'b01000,
        S_DONE   = 5'b10000
    } state_t;

    state_t             state_reg;
    logic [BLOCKS-1:0]  map_reg;
    logic [12:0]        idx_reg;
    logic [12:0]        run_reg;
    logic [12:0]        left_reg;
    logic [12:0]        begin_reg;
    logic               ok_reg;
    logic [OffW-1:0]    off_reg;
    req_t               req_reg;
    logic [12:0]        free_end;

    assign q_pop = q_valid && (state_reg == S_IDLE);
    assign done = (state_reg == S_DONE);
    assign ok = ok_reg;
    assign alloc_offset = off_reg;
    assign free_end = ((14'(req_reg.start) + 14'(req_reg.count)) > 14'(req_reg.limit))
        ? req_reg.limit : 13'(req_reg.start + req_reg.count);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            map_reg <= '0;
            ok_reg <= 1'b0;
            off_reg <= '0;
            idx_reg <= '0;
            run_reg <= '0;
            left_reg <= '0;
            begin_reg <= '0;
            req_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        req_reg <= q_req;
                        ok_reg <= 1'b0;
                        off_reg <= '0;
                        idx_reg <= q_req.op == OP_FREE ? q_req.start : 13'd0;
                        run_reg <= '0;
                        if (q_req.reject)
                        begin
                            state_reg <= S_DONE;
                        end
                        else if (q_req.op == OP_ALLOC)
                        begin
                            state_reg <= S_SEARCH;
                        end
                        else
                        begin
                            state_reg <= S_CLEAR;
                        end
                    end
                end
                S_SEARCH:
                begin
                    // One block per cycle; a used block restarts the run.
                    if (idx_reg >= req_reg.limit)
                    begin
                        state_reg <= S_DONE;
                    end
                    else if (map_reg[idx_reg[IW-1:0]])
                    begin
                        run_reg <= '0;
                        idx_reg <= idx_reg + 13'd1;
                    end
                    else if (run_reg + 13'd1 == req_reg.count)
                    begin
                        begin_reg <= idx_reg + 13'd1 - req_reg.count;
                        idx_reg <= idx_reg + 13'd1 - req_reg.count;
                        left_reg <= req_reg.count;
                        state_reg <= S_MARK;
                    end
                    else
                    begin
                        run_reg <= run_reg + 13'd1;
                        idx_reg <= idx_reg + 13'd1;
                    end
                end
                S_MARK:
                begin
                    if (left_reg == '0)
                    begin
                        ok_reg <= 1'b1;
                        off_reg <= OffW'(37'(begin_reg) << req_reg.shift);
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        map_reg[idx_reg[IW-1:0]] <= 1'b1;
                        idx_reg <= idx_reg + 13'd1;
                        left_reg <= left_reg - 13'd1;
                    end
                end
                S_CLEAR:
                begin
                    if (idx_reg >= free_end)
                    begin
                        ok_reg <= 1'b1;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        map_reg[idx_reg[IW-1:0]] <= 1'b0;
                        idx_reg <= idx_reg + 13'd1;
                    end
                end
                S_DONE:
                begin
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ rtl/bcba_checker.sv @@
// Port-level checks for the allocator top level, bound in below.
// Depends on bitmap_contiguous_block_allocator_core.
module bcba_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic        ok,
    input logic [23:0] alloc_offset
);

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !ok |-> alloc_offset == '0) else $error("failed result has offset");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("result held two cycles");
    a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy) else $error("command not held");

endmodule

bind bitmap_contiguous_block_allocator_core bcba_checker u_chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
    .ok(ok), .alloc_offset(alloc_offset)
);
